>>> rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants of the max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

  localparam int KEY_W    = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_EX_RD,
    S_EX_LD,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } state_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    status_t                 status;
    logic [COUNT_W-1:0]      count;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/mhpq_store.sv
// ----------------------------------------------------------------------------
// mhpq_store
// Heap entry memory: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_store
  import mhpq_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic signed [KEY_W-1:0] wdata,
  input  wire logic [AW-1:0]           raddr0,
  input  wire logic [AW-1:0]           raddr1,
  output      logic signed [KEY_W-1:0] rdata0,
  output      logic signed [KEY_W-1:0] rdata1
);

  logic signed [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

>>> rtl/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for insert (sift up) and extract (sift down) with a hole-based
// walk, plus the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ctrl
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output      logic                    in_ready,
  input  wire op_t                     in_op,
  input  wire logic signed [KEY_W-1:0] in_key,
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      res_t                    out_res,
  output      logic                    we,
  output      logic [AW-1:0]           waddr,
  output      logic signed [KEY_W-1:0] wdata,
  output      logic [AW-1:0]           raddr0,
  output      logic [AW-1:0]           raddr1,
  input  wire logic signed [KEY_W-1:0] rdata0,
  input  wire logic signed [KEY_W-1:0] rdata1
);

  localparam int IW = AW + 2;

  state_t                  state, state_next;
  logic [CW-1:0]           count, count_next;
  logic [AW-1:0]           pos, pos_next;
  logic signed [KEY_W-1:0] key, key_next;
  logic signed [KEY_W-1:0] res_key, res_key_next;
  status_t                 res_status, res_status_next;
  logic                    out_valid_next;
  res_t                    out_res_next;
  logic                    accept;

  logic [IW-1:0]           left_ix, right_ix, cnt_x;
  logic                    left_ok, right_ok;
  logic                    take_left, take_right;
  logic signed [KEY_W-1:0] left_best;
  logic [AW-1:0]           parent;

  assign accept   = in_valid && in_ready;
  assign left_ix  = IW'({pos, 1'b1});
  assign right_ix = left_ix + IW'(1);
  assign cnt_x    = IW'(count);
  assign left_ok  = left_ix < cnt_x;
  assign right_ok = right_ix < cnt_x;
  assign parent   = (pos - AW'(1)) >> 1;

  always_comb begin
    take_left  = left_ok && (rdata0 > key);
    left_best  = take_left ? rdata0 : key;
    take_right = right_ok && (rdata1 > left_best);
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    key_next        = key;
    res_key_next    = res_key;
    res_status_next = res_status;
    out_valid_next  = out_valid;
    out_res_next    = out_res;
    in_ready        = (state == S_IDLE);
    we              = 1'b0;
    waddr           = pos;
    wdata           = key;
    raddr0          = left_ix[AW-1:0];
    raddr1          = right_ix[AW-1:0];

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_key_next    = '0;
          res_status_next = STAT_OK;
          if (in_op == OP_INSERT) begin
            if (count == CW'(CAPACITY)) begin
              res_status_next = STAT_FULL;
              state_next      = S_FIN;
            end else begin
              key_next   = in_key;
              pos_next   = count[AW-1:0];
              count_next = count + CW'(1);
              state_next = S_UP_RD;
            end
          end else begin
            if (count == '0) begin
              res_status_next = STAT_EMPTY;
              state_next      = S_FIN;
            end else begin
              state_next = S_EX_RD;
            end
          end
        end
      end
      S_UP_RD: begin
        raddr0 = parent;
        if (pos == '0) begin
          we         = 1'b1;
          state_next = S_FIN;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (key > rdata0) begin
          wdata      = rdata0;
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_EX_RD: begin
        raddr0     = '0;
        raddr1     = AW'(count - CW'(1));
        state_next = S_EX_LD;
      end
      S_EX_LD: begin
        res_key_next = rdata0;
        key_next     = rdata1;
        count_next   = count - CW'(1);
        pos_next     = '0;
        state_next   = S_DN_RD;
      end
      S_DN_RD: begin
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (take_right) begin
          wdata      = rdata1;
          pos_next   = right_ix[AW-1:0];
          state_next = S_DN_RD;
        end else if (take_left) begin
          wdata      = rdata0;
          pos_next   = left_ix[AW-1:0];
          state_next = S_DN_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_res_next   = '{key: res_key, status: res_status, count: COUNT_W'(count)};
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    key        <= key_next;
    res_key    <= res_key_next;
    res_status <= res_status_next;
    out_res    <= out_res_next;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_UP_RD || state == S_UP_CMP || state == S_DN_CMP))
    else $error("memory write outside a sift step");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> ($past(accept) || $past(state) == S_EX_LD))
    else $error("entry count changed outside insert or extract");

endmodule

`default_nettype wire

>>> rtl/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap priority queue of signed 32-bit keys in a block memory.
//
//  channel  dir  tdata (low bit up)                   tuser
//  s_axis   in   key_in[31:0]                         op (0 insert, 1 extract)
//  m_axis   out  key_out[31:0], count_after[38:32]    status[1:0]
//
// One transaction at a time: the input is closed from acceptance until the
// result is loaded. Each swap of a sift runs a memory read state and then a
// compare/write state; a sift makes at most log2(CAPACITY) swaps.
// Refused or empty-heap transactions skip the memory and go straight to
// the result.
// Reset clears the entry count; no memory clearing pass is needed.
// A stalled output holds the result in its register; the input stays closed
// until that result can be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // key_in[31:0]
  input  wire logic [0:0]  s_axis_tuser,   // op[0]
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [39:0] m_axis_tdata,   // key_out[31:0], count_after[38:32], zero[39]
  output      logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                    we;
  logic [AW-1:0]           waddr, raddr0, raddr1;
  logic signed [KEY_W-1:0] wdata, rdata0, rdata1;
  res_t                    res;

  mhpq_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  mhpq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (op_t'(s_axis_tuser[0])),
    .in_key    (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr0    (raddr0),
    .raddr1    (raddr1),
    .rdata0    (rdata0),
    .rdata1    (rdata1)
  );

  assign m_axis_tdata = {1'b0, res.count, res.key};
  assign m_axis_tuser = res.status;

endmodule

`default_nettype wire
